/* hdl/rgtd_pkg.sv */
// Package for the RDS group text decoder: shared types, item kind codes,
// group type codes and character constants. No dependencies.
package rgtd_pkg;

   // Text and name geometry
   localparam int TEXT_LEN  = 64;
   localparam int NAME_LEN  = 8;
   localparam int ROW_CHARS = 8;
   localparam int TEXT_ROWS = TEXT_LEN / ROW_CHARS;

   // Item kinds (code 3 behaves as a read)
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_GROUP = 2'd0;
   localparam kind_type KIND_READ  = 2'd1;
   localparam kind_type KIND_CLEAR = 2'd2;

   // Group type codes from block B bits 15..12
   typedef logic [3:0] gtype_type;
   localparam gtype_type GTYPE_NAME = 4'd0;
   localparam gtype_type GTYPE_TEXT = 4'd2;

   // Text A/B flag codes: 0 and 1 as received, 2 when none seen yet
   typedef logic [1:0] ab_flag_type;
   localparam ab_flag_type FLAG_NONE = 2'd2;

   // Character constants
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Register index decoded from paddr
   typedef logic csr_index_type;
   localparam csr_index_type CSR_RDS_ENABLE = 1'b0;

   // Command from the group decode to the text store
   typedef struct packed {
      logic        clear;       // clear item: text back to reset
      logic        write;       // decoded type 2 group
      logic        version_b;   // 2B: two characters from block D
      logic        ab;          // text A/B flag of this group
      logic [3:0]  addr;        // text segment address
      logic [15:0] blk_c;
      logic [15:0] blk_d;
      logic [2:0]  read_index;  // slice reported in text_word
   } text_cmd_type;

endpackage

/* hdl/rgtd_req_if.sv */
// Input channel of the RDS group text decoder: valid/ready plus one item.
// Depends on nothing.
interface rgtd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        group_ready;
   logic        group_sync;
   logic [15:0] block_a;
   logic [15:0] block_b;
   logic [15:0] block_c;
   logic [15:0] block_d;
   logic [2:0]  read_index;

   modport source (
      output valid, kind, group_ready, group_sync,
             block_a, block_b, block_c, block_d, read_index,
      input  ready
   );
   modport sink (
      input  valid, kind, group_ready, group_sync,
             block_a, block_b, block_c, block_d, read_index,
      output ready
   );
endinterface

/* hdl/rgtd_rsp_if.sv */
// Result channel of the RDS group text decoder: valid/ready plus one result.
// Depends on nothing.
interface rgtd_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic [15:0] prog_id;
   logic [4:0]  prog_type;
   logic        has_type;
   logic        has_name;
   logic        in_sync;
   logic [63:0] station_name;
   logic [63:0] text_word;

   modport source (
      output valid, changed, prog_id, prog_type, has_type, has_name,
             in_sync, station_name, text_word,
      input  ready
   );
   modport sink (
      input  valid, changed, prog_id, prog_type, has_type, has_name,
             in_sync, station_name, text_word,
      output ready
   );
endinterface

/* hdl/rgtd_text_store.sv */
// Radio text store: 64 characters held as 8 rows of 8, plus the A/B flag.
// Each row compares and updates its own characters. Uses rgtd_pkg.
module rgtd_text_store
   import rgtd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  text_cmd_type cmd,
   output logic         text_changed,
   output logic [63:0]  text_word
);

   logic [63:0]  row_ff [TEXT_ROWS];
   logic [63:0]  row_in [TEXT_ROWS];
   ab_flag_type  flag_ff;
   ab_flag_type  flag_in;
   logic         toggle;
   logic         any_diff;

   // Stored form of a text byte
   function automatic logic [7:0] text_byte(input logic [7:0] c);
      logic [7:0] r;
      if (c == CHAR_CR) begin
         r = CHAR_NUL;
      end else if (c != CHAR_NUL && c < CHAR_SPACE) begin
         r = CHAR_SPACE;
      end else begin
         r = c;
      end
      return r;
   endfunction

   assign toggle = cmd.write && ({1'b0, cmd.ab} != flag_ff);

   // Per-row update: optional clear, then the group's characters
   always_comb begin
      logic [5:0]  pos;
      logic        hit;
      logic [7:0]  wbyte;
      logic [7:0]  old_byte;
      logic [63:0] base;
      any_diff = 1'b0;
      for (int r = 0; r < TEXT_ROWS; r++) begin
         base = (cmd.clear || toggle) ? 64'd0 : row_ff[r];
         row_in[r] = row_ff[r];
         for (int i = 0; i < ROW_CHARS; i++) begin
            pos = 6'(r * ROW_CHARS + i);
            if (cmd.version_b) begin
               hit = !pos[5] && (pos[4:1] == cmd.addr);
               wbyte = pos[0] ? cmd.blk_d[7:0] : cmd.blk_d[15:8];
            end else begin
               hit = (pos[5:2] == cmd.addr);
               unique case (pos[1:0])
                  2'd0: wbyte = cmd.blk_c[15:8];
                  2'd1: wbyte = cmd.blk_c[7:0];
                  2'd2: wbyte = cmd.blk_d[15:8];
                  default: wbyte = cmd.blk_d[7:0];
               endcase
            end
            hit = hit && cmd.write && !cmd.clear;
            wbyte = text_byte(wbyte);
            old_byte = base[63 - 8 * i -: 8];
            if (hit && (wbyte != old_byte)) begin
               any_diff = 1'b1;
            end
            if (cmd.clear || cmd.write) begin
               row_in[r][63 - 8 * i -: 8] = hit ? wbyte : old_byte;
            end
         end
      end
   end

   // A/B flag
   always_comb begin
      priority if (cmd.clear) begin
         flag_in = FLAG_NONE;
      end else if (cmd.write) begin
         flag_in = {1'b0, cmd.ab};
      end else begin
         flag_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= FLAG_NONE;
         for (int r = 0; r < TEXT_ROWS; r++) begin
            row_ff[r] <= 64'd0;
         end
      end else begin
         flag_ff <= flag_in;
         for (int r = 0; r < TEXT_ROWS; r++) begin
            row_ff[r] <= row_in[r];
         end
      end
   end

   // Reported values reflect this item's update
   assign text_changed = toggle || any_diff;
   assign text_word    = row_in[cmd.read_index];

endmodule

/* hdl/rds_group_text_decoder.sv */
// Top level of the RDS group text decoder: input register, group decode,
// name registers and result register. Uses rgtd_pkg, rgtd_req_if, rgtd_rsp_if
// and rgtd_text_store.
//
// Takes one item per clock from the req channel while rsp is not stalled. An
// item lands in an input register; when the result register is free, its
// state update (PI, PTY, station name, radio text) is done by the character
// update logic and stored in the same cycle as its result is loaded into the
// result register, which drives the rsp channel. While a result waits on rsp,
// one more item is taken and held. The rds_enable register (byte address 0)
// gates group items; write it only while no item is in flight.
module rds_group_text_decoder
   import rgtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // Channels
   rgtd_req_if.sink    req_ch,
   rgtd_rsp_if.source  rsp_ch
);

   // Configuration
   logic enable_ff;
   logic csr_write;

   // Input register
   logic        s1_valid_ff;
   kind_type    s1_kind_ff;
   logic        s1_ready_ff;
   logic        s1_sync_ff;
   logic [15:0] s1_a_ff;
   logic [15:0] s1_b_ff;
   logic [15:0] s1_c_ff;
   logic [15:0] s1_d_ff;
   logic [2:0]  s1_index_ff;

   // Decoder state
   logic [7:0]  name_ff [NAME_LEN];
   logic [7:0]  name_in [NAME_LEN];
   logic [15:0] pi_ff;
   logic [15:0] pi_in;
   logic [4:0]  pty_ff;
   logic [4:0]  pty_in;
   logic        name_seen_ff;
   logic        name_seen_in;
   logic        sync_ff;
   logic        sync_in;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_changed_ff;
   logic [15:0] rsp_pi_ff;
   logic [4:0]  rsp_pty_ff;
   logic        rsp_has_name_ff;
   logic        rsp_sync_ff;
   logic [63:0] rsp_name_ff;
   logic [63:0] rsp_text_ff;

   logic         advance;
   logic         take;
   logic         is_clear;
   logic         decode;
   gtype_type    gtype;
   logic         name_changed;
   logic         text_changed;
   logic [63:0]  text_word;
   logic [63:0]  name_word;
   text_cmd_type text_cmd;

   // APB register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_RDS_ENABLE);
   assign csr_prdata = (csr_paddr[2] == CSR_RDS_ENABLE) ? {31'd0, enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   // Handshake: the input register moves on when the result register frees
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_kind_ff  <= req_ch.kind;
         s1_ready_ff <= req_ch.group_ready;
         s1_sync_ff  <= req_ch.group_sync;
         s1_a_ff     <= req_ch.block_a;
         s1_b_ff     <= req_ch.block_b;
         s1_c_ff     <= req_ch.block_c;
         s1_d_ff     <= req_ch.block_d;
         s1_index_ff <= req_ch.read_index;
      end
   end

   // Group decode
   assign gtype    = s1_b_ff[15:12];
   assign is_clear = advance && (s1_kind_ff == KIND_CLEAR);
   assign decode   = advance && (s1_kind_ff == KIND_GROUP) && enable_ff && s1_ready_ff;

   always_comb begin
      logic [7:0] c1;
      logic [7:0] c2;
      logic [2:0] pos;
      c1 = (s1_d_ff[15:8] < CHAR_SPACE) ? CHAR_SPACE : s1_d_ff[15:8];
      c2 = (s1_d_ff[7:0] < CHAR_SPACE) ? CHAR_SPACE : s1_d_ff[7:0];
      pos = {s1_b_ff[1:0], 1'b0};
      for (int i = 0; i < NAME_LEN; i++) begin
         name_in[i] = name_ff[i];
      end
      pi_in        = pi_ff;
      pty_in       = pty_ff;
      name_seen_in = name_seen_ff;
      sync_in      = sync_ff;
      name_changed = 1'b0;
      if (is_clear) begin
         for (int i = 0; i < NAME_LEN; i++) begin
            name_in[i] = CHAR_NUL;
         end
         pi_in        = 16'd0;
         pty_in       = 5'd0;
         name_seen_in = 1'b0;
         sync_in      = 1'b0;
      end else begin
         if (advance && (s1_kind_ff == KIND_GROUP) && enable_ff) begin
            sync_in = s1_sync_ff;
         end
         if (decode) begin
            pi_in  = s1_a_ff;
            pty_in = s1_b_ff[9:5];
            if (gtype == GTYPE_NAME) begin
               name_changed = (name_ff[pos] != c1) || (name_ff[pos + 3'd1] != c2);
               name_in[pos]        = c1;
               name_in[pos + 3'd1] = c2;
               name_seen_in        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pi_ff        <= 16'd0;
         pty_ff       <= 5'd0;
         name_seen_ff <= 1'b0;
         sync_ff      <= 1'b0;
         for (int i = 0; i < NAME_LEN; i++) begin
            name_ff[i] <= CHAR_NUL;
         end
      end else begin
         pi_ff        <= pi_in;
         pty_ff       <= pty_in;
         name_seen_ff <= name_seen_in;
         sync_ff      <= sync_in;
         for (int i = 0; i < NAME_LEN; i++) begin
            name_ff[i] <= name_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NAME_LEN; i++) begin
         name_word[63 - 8 * i -: 8] = name_in[i];
      end
   end

   // Radio text
   always_comb begin
      text_cmd.clear      = is_clear;
      text_cmd.write      = decode && (gtype == GTYPE_TEXT);
      text_cmd.version_b  = s1_b_ff[11];
      text_cmd.ab         = s1_b_ff[4];
      text_cmd.addr       = s1_b_ff[3:0];
      text_cmd.blk_c      = s1_c_ff;
      text_cmd.blk_d      = s1_d_ff;
      text_cmd.read_index = s1_index_ff;
   end

   rgtd_text_store u_text (
      .clock        (clock),
      .reset        (reset),
      .cmd          (text_cmd),
      .text_changed (text_changed),
      .text_word    (text_word)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_changed_ff  <= name_changed || (text_cmd.write && text_changed);
         rsp_pi_ff       <= pi_in;
         rsp_pty_ff      <= pty_in;
         rsp_has_name_ff <= name_seen_in;
         rsp_sync_ff     <= sync_in;
         rsp_name_ff     <= name_word;
         rsp_text_ff     <= text_word;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.changed      = rsp_changed_ff;
   assign rsp_ch.prog_id      = rsp_pi_ff;
   assign rsp_ch.prog_type    = rsp_pty_ff;
   assign rsp_ch.has_type     = (rsp_pty_ff != 5'd0);
   assign rsp_ch.has_name     = rsp_has_name_ff;
   assign rsp_ch.in_sync      = rsp_sync_ff;
   assign rsp_ch.station_name = rsp_name_ff;
   assign rsp_ch.text_word    = rsp_text_ff;

endmodule

/* dv/tb.sv */
// Self-checking bench for rds_group_text_decoder: directed and random RDS items,
// an in-bench decoder model, APB writes of rds_enable and a result scoreboard.
// Depends on rgtd_pkg, rgtd_req_if, rgtd_rsp_if and the decoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rgtd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int CHUNK_ITEMS    = 105;
   localparam int HOLD_CYCLES    = 60;
   localparam int BURST_ITEMS    = 12;
   localparam kind_type KIND_SPARE = 2'd3;   // unused code, decoded as a read
   localparam logic [2:0] ADDR_RDS_ENABLE = {CSR_RDS_ENABLE, 2'b00};

   typedef struct {
      kind_type    kind;
      logic        group_ready;
      logic        group_sync;
      logic [15:0] block_a;
      logic [15:0] block_b;
      logic [15:0] block_c;
      logic [15:0] block_d;
      logic [2:0]  read_index;
   } rds_item_type;

   typedef struct {
      logic        changed;
      logic [15:0] prog_id;
      logic [4:0]  prog_type;
      logic        has_type;
      logic        has_name;
      logic        in_sync;
      logic [63:0] station_name;
      logic [63:0] text_word;
   } rds_report_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rgtd_req_if req_ch ();
   rgtd_rsp_if rsp_ch ();

   rds_group_text_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Decoder model state
   logic [7:0]  name_mem [NAME_LEN];
   logic [7:0]  text_mem [TEXT_LEN];
   ab_flag_type ab_state;
   logic [15:0] pi_code;
   logic [4:0]  pty_code;
   logic        name_flag;
   logic        sync_flag;
   logic        rds_on;

   rds_report_type due_reports [$];
   int  tx_idle_pct = 24;
   int  rx_idle_pct = 76;
   int  hold_left   = 0;
   int  items_sent  = 0;
   int  reports_checked = 0;
   int  changed_reports = 0;
   int  errors      = 0;
   int  directed_items  = 0;
   logic text_ab_pick = 1'b0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------------------------------------------------------- model
   function automatic void clear_decoder_state();
      foreach (name_mem[i]) name_mem[i] = CHAR_NUL;
      foreach (text_mem[i]) text_mem[i] = CHAR_NUL;
      ab_state  = FLAG_NONE;
      pi_code   = '0;
      pty_code  = '0;
      name_flag = 1'b0;
      sync_flag = 1'b0;
   endfunction

   // CR ends the text, other control bytes read as space
   function automatic logic [7:0] text_char(input logic [7:0] c);
      if (c == CHAR_CR) return CHAR_NUL;
      if (c != CHAR_NUL && c < CHAR_SPACE) return CHAR_SPACE;
      return c;
   endfunction

   function automatic bit store_text(input int pos, input logic [7:0] c);
      logic [7:0] v;
      v = text_char(c);
      if (text_mem[pos] == v) return 1'b0;
      text_mem[pos] = v;
      return 1'b1;
   endfunction

   function automatic void predict_report(input rds_item_type it, output rds_report_type rep);
      gtype_type  gt;
      int         base;
      bit         chg;
      logic [7:0] n1;
      logic [7:0] n2;
      chg = 1'b0;
      if (it.kind == KIND_GROUP) begin
         if (rds_on) begin
            sync_flag = it.group_sync;
            if (it.group_ready) begin
               pi_code  = it.block_a;
               pty_code = it.block_b[9:5];
               gt = it.block_b[15:12];
               if (gt == GTYPE_NAME) begin
                  // two name characters, control bytes as space
                  base = int'(it.block_b[1:0]) * 2;
                  n1 = it.block_d[15:8];
                  n2 = it.block_d[7:0];
                  if (n1 < CHAR_SPACE) n1 = CHAR_SPACE;
                  if (n2 < CHAR_SPACE) n2 = CHAR_SPACE;
                  if (name_mem[base] != n1 || name_mem[base+1] != n2) chg = 1'b1;
                  name_mem[base]   = n1;
                  name_mem[base+1] = n2;
                  name_flag = 1'b1;
               end else if (gt == GTYPE_TEXT) begin
                  // A/B toggle wipes the text first
                  if ({1'b0, it.block_b[4]} != ab_state) begin
                     foreach (text_mem[i]) text_mem[i] = CHAR_NUL;
                     ab_state = {1'b0, it.block_b[4]};
                     chg = 1'b1;
                  end
                  base = int'(it.block_b[3:0]);
                  if (!it.block_b[11]) begin
                     base = base * 4;
                     if (store_text(base,     it.block_c[15:8])) chg = 1'b1;
                     if (store_text(base + 1, it.block_c[7:0]))  chg = 1'b1;
                     if (store_text(base + 2, it.block_d[15:8])) chg = 1'b1;
                     if (store_text(base + 3, it.block_d[7:0]))  chg = 1'b1;
                  end else begin
                     base = base * 2;
                     if (store_text(base,     it.block_d[15:8])) chg = 1'b1;
                     if (store_text(base + 1, it.block_d[7:0]))  chg = 1'b1;
                  end
               end
            end
         end
      end else if (it.kind == KIND_CLEAR) begin
         clear_decoder_state();
      end
      rep.changed   = chg;
      rep.prog_id   = pi_code;
      rep.prog_type = pty_code;
      rep.has_type  = (pty_code != '0);
      rep.has_name  = name_flag;
      rep.in_sync   = sync_flag;
      rep.station_name = '0;
      rep.text_word    = '0;
      for (int i = 0; i < NAME_LEN; i++)
         rep.station_name = {rep.station_name[55:0], name_mem[i]};
      for (int i = 0; i < ROW_CHARS; i++)
         rep.text_word = {rep.text_word[55:0], text_mem[int'(it.read_index)*ROW_CHARS + i]};
   endfunction

   // ---------------------------------------------------------------- item builders
   function automatic logic [15:0] make_block_b(input gtype_type gt, input logic version,
                                                input logic [4:0] pty, input logic ab,
                                                input logic [3:0] addr);
      return {gt, version, 1'b0, pty, ab, addr};
   endfunction

   function automatic rds_item_type make_group(input logic rdy, input logic sync,
                                               input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] c, input logic [15:0] d);
      rds_item_type it;
      it.kind = KIND_GROUP;
      it.group_ready = rdy;
      it.group_sync  = sync;
      it.block_a = a;
      it.block_b = b;
      it.block_c = c;
      it.block_d = d;
      it.read_index = '0;
      return it;
   endfunction

   function automatic rds_item_type make_other(input kind_type k, input logic [2:0] idx);
      rds_item_type it;
      it = make_group(1'b1, 1'b1, 16'h5A5A, 16'h2000, 16'h4142, 16'h4344);
      it.kind = k;
      it.read_index = idx;
      return it;
   endfunction

   function automatic logic [7:0] rand_char();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
      if (r < 65) return CHAR_CR;
      if (r < 78) return 8'($urandom_range(0, 31));
      return 8'($urandom_range(128, 255));
   endfunction

   // mostly well-formed name and text groups on a stable A/B flag
   function automatic rds_item_type random_item();
      rds_item_type it;
      int r;
      gtype_type gt;
      r = $urandom_range(99);
      if ($urandom_range(99) < 6) text_ab_pick = ~text_ab_pick;
      if (r < 40)      gt = GTYPE_NAME;
      else if (r < 85) gt = GTYPE_TEXT;
      else             gt = 4'($urandom);
      it = make_group($urandom_range(99) < 90, 1'($urandom), 16'($urandom), 16'($urandom),
                      {rand_char(), rand_char()}, {rand_char(), rand_char()});
      it.block_b[15:12] = gt;
      it.block_b[4]     = text_ab_pick;
      it.read_index     = 3'($urandom);
      r = $urandom_range(99);
      if (r >= 91)      it.kind = KIND_SPARE;
      else if (r >= 88) it.kind = KIND_CLEAR;
      else if (r >= 72) it.kind = KIND_READ;
      return it;
   endfunction

   // ---------------------------------------------------------------- channel and csr drivers
   task automatic send_item(input rds_item_type it);
      int gap;
      rds_report_type rep;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= it.kind;
      req_ch.group_ready <= it.group_ready;
      req_ch.group_sync  <= it.group_sync;
      req_ch.block_a     <= it.block_a;
      req_ch.block_b     <= it.block_b;
      req_ch.block_c     <= it.block_c;
      req_ch.block_d     <= it.block_d;
      req_ch.read_index  <= it.read_index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_report(it, rep);
      due_reports.push_back(rep);
      items_sent++;
   endtask

   task automatic wait_reports_drained();
      req_ch.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic on);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_RDS_ENABLE;
      csr_pwdata  <= 32'(on);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rds_on = on;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // read back the register just written
      @(posedge clock);
      check_field("csr_prdata", 64'(on), 64'(csr_prdata));
   endtask

   // ---------------------------------------------------------------- receiver and checker
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rds_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (due_reports.size() == 0) begin
            $display("%0t: result transfer with no item outstanding", $time);
            errors++;
         end else begin
            want = due_reports.pop_front();
            check_field("changed",      64'(want.changed),   64'(rsp_ch.changed));
            check_field("prog_id",      64'(want.prog_id),   64'(rsp_ch.prog_id));
            check_field("prog_type",    64'(want.prog_type), 64'(rsp_ch.prog_type));
            check_field("has_type",     64'(want.has_type),  64'(rsp_ch.has_type));
            check_field("has_name",     64'(want.has_name),  64'(rsp_ch.has_name));
            check_field("in_sync",      64'(want.in_sync),   64'(rsp_ch.in_sync));
            check_field("station_name", want.station_name,   rsp_ch.station_name);
            check_field("text_word",    want.text_word,      rsp_ch.text_word);
            reports_checked++;
            if (want.changed) changed_reports++;
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- tests
   task automatic test_disabled_groups();
      write_enable(1'b0);
      send_item(make_group(1'b1, 1'b1, 16'hFFFF, make_block_b(GTYPE_NAME, 1'b0, 5'd31, 1'b1, 4'd3),
                           16'h0000, 16'h4142));
      send_item(make_group(1'b1, 1'b1, 16'h1234, make_block_b(GTYPE_TEXT, 1'b0, 5'd7, 1'b0, 4'd0),
                           16'h4142, 16'h4344));
   endtask

   task automatic test_station_name();
      wait_reports_drained();
      write_enable(1'b1);
      send_item(make_group(1'b1, 1'b1, 16'h0000, make_block_b(GTYPE_NAME, 1'b0, 5'd0, 1'b0, 4'd0),
                           16'hFFFF, 16'h001F));
      send_item(make_group(1'b1, 1'b0, 16'hC201, make_block_b(GTYPE_NAME, 1'b1, 5'd1, 1'b1, 4'd1),
                           16'h0000, 16'h2020));
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_NAME, 1'b0, 5'd10, 1'b0, 4'd2),
                           16'h0000, 16'hFF80));
      send_item(make_group(1'b1, 1'b1, 16'hFFFF, make_block_b(GTYPE_NAME, 1'b0, 5'd31, 1'b0, 4'd3),
                           16'h0000, 16'h7E41));
      // same characters again: nothing changes
      send_item(make_group(1'b1, 1'b1, 16'hFFFF, make_block_b(GTYPE_NAME, 1'b0, 5'd31, 1'b0, 4'd3),
                           16'h0000, 16'h7E41));
      // group not ready: only the sync flag is taken
      send_item(make_group(1'b0, 1'b0, 16'h0BAD, make_block_b(GTYPE_NAME, 1'b0, 5'd3, 1'b0, 4'd0),
                           16'h0000, 16'h5858));
   endtask

   task automatic test_radio_text();
      // CR, control byte, NUL and a high byte in one 2A segment
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_TEXT, 1'b0, 5'd5, 1'b0, 4'd0),
                           16'h0D01, 16'h0080));
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_TEXT, 1'b0, 5'd5, 1'b0, 4'd15),
                           16'hFFFF, 16'h2041));
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_TEXT, 1'b1, 5'd5, 1'b0, 4'd15),
                           16'h0000, 16'h0D7F));
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_TEXT, 1'b1, 5'd5, 1'b0, 4'd15),
                           16'h0000, 16'h0D7F));
      // A/B toggle clears the text before the write
      send_item(make_group(1'b1, 1'b1, 16'hC201, make_block_b(GTYPE_TEXT, 1'b0, 5'd5, 1'b1, 4'd1),
                           16'h4142, 16'h4344));
      // other group types only carry PI and PTY
      send_item(make_group(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_group(1'b1, 1'b0, 16'h0000, 16'h1000, 16'h0000, 16'h0000));
   endtask

   task automatic test_reads_and_clear();
      send_item(make_other(KIND_READ, 3'd0));
      send_item(make_other(KIND_READ, 3'd7));
      send_item(make_other(KIND_SPARE, 3'd3));
      send_item(make_other(KIND_CLEAR, 3'd0));
      // clear also works with groups disabled
      wait_reports_drained();
      write_enable(1'b0);
      send_item(make_group(1'b1, 1'b1, 16'h1111, make_block_b(GTYPE_NAME, 1'b0, 5'd2, 1'b0, 4'd0),
                           16'h0000, 16'h4142));
      send_item(make_other(KIND_CLEAR, 3'd1));
      wait_reports_drained();
      write_enable(1'b1);
      directed_items = items_sent;
   endtask

   // stall results for a long stretch while items keep coming
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = tx_idle_pct;
      tx_idle_pct = 0;
      hold_left = HOLD_CYCLES;
      repeat (BURST_ITEMS) send_item(random_item());
      tx_idle_pct = saved_pct;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 76 : 0;
         rx_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 24 : 0;
         for (int chunk = 0; chunk < 3; chunk++) begin
            wait_reports_drained();
            write_enable($urandom_range(4) != 0);
            repeat (CHUNK_ITEMS) send_item(random_item());
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_READ;
      req_ch.group_ready <= 1'b0;
      req_ch.group_sync  <= 1'b0;
      req_ch.block_a     <= '0;
      req_ch.block_b     <= '0;
      req_ch.block_c     <= '0;
      req_ch.block_d     <= '0;
      req_ch.read_index  <= '0;
      clear_decoder_state();
      rds_on = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_disabled_groups();
      test_station_name();
      test_radio_text();
      test_reads_and_clear();
      test_backpressure();
      test_random_traffic();

      wait_reports_drained();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items (%0d directed), %0d results checked, %0d with changes,",
               items_sent, directed_items, reports_checked, changed_reports);
      $display("three idle mixes, a long result stall and both rds_enable settings.");
      if (errors == 0 && due_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/rgtd_pkg.sv
hdl/rgtd_req_if.sv
hdl/rgtd_rsp_if.sv
hdl/rgtd_text_store.sv
hdl/rds_group_text_decoder.sv
dv/tb.sv
